[rtl/mersenne_twister_rng_assert.svh]
// Assertion macros used by the generator's sequencer.
`ifndef MERSENNE_TWISTER_RNG_ASSERT_SVH
`define MERSENNE_TWISTER_RNG_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTR_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed in generator control");

// The consequent must hold in the cycle after the antecedent.
`define MTR_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed in generator control");

`endif

[rtl/mtr_pkg.sv]
package mtr_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int WORD_W       = 32;
   localparam int IDX_W        = $clog2(STATE_WORDS);
   localparam int POS_W        = $clog2(STATE_WORDS + 1);
   localparam int MAX_REJECTS  = 255;
   localparam int TRY_W        = $clog2(MAX_REJECTS + 1);

   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908B0DF;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC60000;
   localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
   localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7FFFFFFF;

   localparam logic [1:0] OP_SEED  = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_BELOW = 2'd2;
   // Spare code: leaves the state alone and answers zero.
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic load_req;
      logic seed_start;
      logic seed_mul;
      logic seed_write;
      logic twist_start;
      logic twist_read;
      logic twist_write;
      logic fetch;
      logic temper;
      logic clear_result;
      logic floor_start;
      logic div_start;
      logic div_use_draw;
      logic floor_capture;
      logic try_next;
      logic mod_capture;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       req_small;
      logic       is_below;
      logic       idx_last;
      logic       pos_full;
      logic       div_busy;
      logic       div_done;
      logic       reject;
      logic       tries_max;
      logic       out_busy;
   } status_type;

endpackage

[rtl/mtr_req_if.sv]
interface mtr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] argument;

   modport source (output valid, output operation, output argument, input ready);
   modport sink (input valid, input operation, input argument, output ready);
endinterface

[rtl/mtr_rsp_if.sv]
interface mtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

[rtl/mtr_divider.sv]
// Restoring divider that yields the remainder only, one bit per cycle.
module mtr_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mtr_pkg::WORD_W-1:0] dividend,
   input  logic [mtr_pkg::WORD_W-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [mtr_pkg::WORD_W-1:0] remainder
);

   localparam int CNT_W = $clog2(mtr_pkg::WORD_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [mtr_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [mtr_pkg::WORD_W-1:0] dvd_ff, dvd_in;
   logic [mtr_pkg::WORD_W-1:0] dvs_ff, dvs_in;
   logic [mtr_pkg::WORD_W:0]   partial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      partial  = {rem_ff, dvd_ff[mtr_pkg::WORD_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(mtr_pkg::WORD_W - 1);
         rem_in   = '0;
         dvd_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[mtr_pkg::WORD_W-2:0], 1'b0};
         if (partial >= {1'b0, dvs_ff}) begin
            rem_in = mtr_pkg::WORD_W'(partial - {1'b0, dvs_ff});
         end else begin
            rem_in = partial[mtr_pkg::WORD_W-1:0];
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[rtl/mtr_datapath.sv]
// Word store, seeding and twisting arithmetic, tempering, bound check and result slot.
module mtr_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  mtr_pkg::cmd_type           cmd,
   output mtr_pkg::status_type        status,
   input  logic [1:0]                 req_operation,
   input  logic [mtr_pkg::WORD_W-1:0] req_argument,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [mtr_pkg::WORD_W-1:0] rsp_value
);

   localparam int W  = mtr_pkg::WORD_W;
   localparam int IW = mtr_pkg::IDX_W;
   localparam int PW = mtr_pkg::POS_W;

   logic [W-1:0] mem [mtr_pkg::STATE_WORDS];

   logic [1:0]                op_ff;
   logic [W-1:0]              arg_ff;
   logic [W-1:0]              w_ff, prod_ff, cur_ff;
   logic [W-1:0]              rd_a_ff, rd_b_ff;
   logic [W-1:0]              draw_ff, floor_ff, result_ff;
   logic [IW-1:0]             idx_ff;
   logic [PW-1:0]             pos_ff;
   logic                      seeded_ff;
   logic [mtr_pkg::TRY_W-1:0] tries_ff;
   logic                      rsp_valid_ff;
   logic [W-1:0]              rsp_value_ff;

   logic          we, re;
   logic [IW-1:0] wa, ra, rb, nxt_idx, far_idx;
   logic [W-1:0]  wd, seed_word, twist_word, word_a, word_b, word_cur, x;
   logic [IW:0]   far_sum;
   logic          div_busy, div_done;
   logic [W-1:0]  div_rem;

   function automatic logic [W-1:0] temper(input logic [W-1:0] v);
      logic [W-1:0] y;
      y = v ^ (v >> 11);
      y = y ^ ((y << 7) & mtr_pkg::TEMPER_B);
      y = y ^ ((y << 15) & mtr_pkg::TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // An unseeded store reads as all zero, and twisting zeros leaves zeros.
   assign word_a   = seeded_ff ? rd_a_ff : '0;
   assign word_b   = seeded_ff ? rd_b_ff : '0;
   assign word_cur = seeded_ff ? cur_ff : '0;

   assign nxt_idx = (idx_ff == IW'(mtr_pkg::STATE_WORDS - 1)) ? '0 : idx_ff + 1'b1;
   assign far_sum = {1'b0, idx_ff} + (IW+1)'(mtr_pkg::TWIST_OFFSET);
   assign far_idx = (far_sum >= (IW+1)'(mtr_pkg::STATE_WORDS)) ?
                    IW'(far_sum - (IW+1)'(mtr_pkg::STATE_WORDS)) : far_sum[IW-1:0];

   assign x          = (word_cur & mtr_pkg::HIGH_BIT) | (word_a & mtr_pkg::LOW_BITS);
   assign twist_word = word_b ^ (x >> 1) ^ (x[0] ? mtr_pkg::TWIST_MATRIX : '0);
   assign seed_word  = prod_ff + W'(idx_ff);

   always_comb begin
      we = 1'b0;
      wa = idx_ff;
      wd = twist_word;
      if (cmd.seed_start) begin
         we = 1'b1;
         wa = '0;
         wd = arg_ff;
      end else if (cmd.seed_write) begin
         we = 1'b1;
         wd = seed_word;
      end else if (cmd.twist_write) begin
         we = 1'b1;
      end
      re = cmd.twist_start | cmd.twist_read | cmd.fetch;
      ra = cmd.twist_start ? '0 : (cmd.fetch ? IW'(pos_ff) : nxt_idx);
      rb = far_idx;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_a_ff <= mem[ra];
         rd_b_ff <= mem[rb];
      end
   end

   mtr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cmd.div_use_draw ? draw_ff : W'(0) - arg_ff),
      .divisor   (arg_ff),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.seed_start) begin
            seeded_ff <= 1'b1;
         end
         if (cmd.seed_write && status.idx_last) begin
            pos_ff <= PW'(mtr_pkg::STATE_WORDS);
         end else if (cmd.twist_write && status.idx_last) begin
            pos_ff <= '0;
         end else if (cmd.temper) begin
            pos_ff <= pos_ff + 1'b1;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_req) begin
         op_ff  <= req_operation;
         arg_ff <= req_argument;
      end
      if (cmd.seed_start) begin
         w_ff   <= arg_ff;
         idx_ff <= IW'(1);
      end
      if (cmd.seed_mul) begin
         prod_ff <= mtr_pkg::SEED_MULT * (w_ff ^ (w_ff >> 30));
      end
      if (cmd.seed_write) begin
         w_ff   <= seed_word;
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.twist_start) begin
         idx_ff <= '0;
      end
      if (cmd.twist_read) begin
         cur_ff <= rd_a_ff;
      end
      if (cmd.twist_write) begin
         idx_ff <= nxt_idx;
      end
      if (cmd.temper) begin
         draw_ff   <= temper(word_a);
         result_ff <= temper(word_a);
      end
      if (cmd.floor_start) begin
         tries_ff <= '0;
      end
      if (cmd.floor_capture) begin
         floor_ff <= div_rem;
      end
      if (cmd.try_next) begin
         tries_ff <= tries_ff + 1'b1;
      end
      if (cmd.mod_capture) begin
         result_ff <= div_rem;
      end
      if (cmd.clear_result) begin
         result_ff <= '0;
      end
      if (cmd.push) begin
         rsp_value_ff <= result_ff;
      end
   end

   always_comb begin
      status.req_op    = req_operation;
      status.req_small = req_argument < W'(2);
      status.is_below  = op_ff == mtr_pkg::OP_BELOW;
      status.idx_last  = idx_ff == IW'(mtr_pkg::STATE_WORDS - 1);
      status.pos_full  = pos_ff == PW'(mtr_pkg::STATE_WORDS);
      status.div_busy  = div_busy;
      status.div_done  = div_done;
      status.reject    = draw_ff < floor_ff;
      status.tries_max = tries_ff == mtr_pkg::TRY_W'(mtr_pkg::MAX_REJECTS);
      status.out_busy  = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

[rtl/mtr_ctrl.sv]
// Sequencer for seeding, twisting, drawing and the bounded draw.
module mtr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mtr_pkg::status_type status,
   output mtr_pkg::cmd_type    cmd
);

   typedef enum logic [12:0] {
      IDLE        = 13'b0000000000001,
      SEED_MUL    = 13'b0000000000010,
      SEED_WR     = 13'b0000000000100,
      DRAW_START  = 13'b0000000001000,
      TW_PRIME    = 13'b0000000010000,
      TW_READ     = 13'b0000000100000,
      TW_WRITE    = 13'b0000001000000,
      FETCH       = 13'b0000010000000,
      TEMPER      = 13'b0000100000000,
      CHECK       = 13'b0001000000000,
      FLOOR_START = 13'b0010000000000,
      DIV_WAIT    = 13'b0100000000000,
      REPLY       = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      mod_phase_ff, mod_phase_in;

   always_comb begin
      state_in     = state_ff;
      mod_phase_in = mod_phase_ff;
      cmd          = '0;
      req_ready    = state_ff == IDLE;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (status.req_op)
                  mtr_pkg::OP_SEED: begin
                     state_in = SEED_MUL;
                  end
                  mtr_pkg::OP_DRAW: begin
                     state_in = DRAW_START;
                  end
                  mtr_pkg::OP_BELOW: begin
                     state_in = status.req_small ? REPLY : FLOOR_START;
                  end
                  default: begin
                     state_in = REPLY;
                  end
               endcase
               cmd.clear_result = 1'b1;
            end
         end
         // The first word is written here and latched for the multiplier, which works on it in SEED_WR.
         SEED_MUL: begin
            cmd.seed_start = 1'b1;
            state_in       = SEED_WR;
            mod_phase_in   = 1'b0;
         end
         SEED_WR: begin
            if (!mod_phase_ff) begin
               cmd.seed_mul = 1'b1;
               mod_phase_in = 1'b1;
            end else begin
               cmd.seed_write = 1'b1;
               mod_phase_in   = 1'b0;
               if (status.idx_last) begin
                  state_in = REPLY;
               end
            end
         end
         DRAW_START: begin
            state_in = status.pos_full ? TW_PRIME : FETCH;
         end
         TW_PRIME: begin
            cmd.twist_start = 1'b1;
            state_in        = TW_READ;
         end
         TW_READ: begin
            cmd.twist_read = 1'b1;
            state_in       = TW_WRITE;
         end
         TW_WRITE: begin
            cmd.twist_write = 1'b1;
            state_in        = status.idx_last ? FETCH : TW_READ;
         end
         FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = TEMPER;
         end
         TEMPER: begin
            cmd.temper = 1'b1;
            state_in   = status.is_below ? CHECK : REPLY;
         end
         CHECK: begin
            if (status.reject && !status.tries_max) begin
               cmd.try_next = 1'b1;
               state_in     = DRAW_START;
            end else begin
               cmd.div_start    = 1'b1;
               cmd.div_use_draw = 1'b1;
               mod_phase_in     = 1'b1;
               state_in         = DIV_WAIT;
            end
         end
         FLOOR_START: begin
            cmd.floor_start = 1'b1;
            cmd.div_start   = 1'b1;
            mod_phase_in    = 1'b0;
            state_in        = DIV_WAIT;
         end
         DIV_WAIT: begin
            if (status.div_done) begin
               if (mod_phase_ff) begin
                  cmd.mod_capture = 1'b1;
                  state_in        = REPLY;
               end else begin
                  cmd.floor_capture = 1'b1;
                  state_in          = DRAW_START;
               end
            end
         end
         REPLY: begin
            if (!status.out_busy) begin
               cmd.push = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         mod_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_phase_ff <= mod_phase_in;
      end
   end

`include "mersenne_twister_rng_assert.svh"

   `MTR_ASSERT_NEXT(a_div_started, clock, reset, cmd.div_start, status.div_busy)
   `MTR_ASSERT_SAME(a_fetch_in_range, clock, reset, state_ff == FETCH, !status.pos_full)
   `MTR_ASSERT_NEXT(a_twist_ends, clock, reset, cmd.twist_write && status.idx_last, state_ff == FETCH)
   `MTR_ASSERT_NEXT(a_reply_leaves, clock, reset, cmd.push, state_ff == IDLE)

endmodule

[rtl/mersenne_twister_rng.sv]
// MT19937 random number generator with a 624-word store. Each request carries an operation:
// reseed fills the store from the argument and answers zero, a raw draw answers the next
// tempered word, and a bounded draw answers a value below the argument (zero for a bound
// below two), unbiased unless 255 words in a row were rejected. Every 624th draw first
// regenerates the store, where each word needs a read of its neighbour and its far
// partner through the store's ports before its write. Reseeding runs the seed
// multiplier and then the write for each word. A bounded draw adds two remainder
// computations in the one-bit-a-cycle divider, plus a raw draw for every rejected word.
// After reset the store needs no clearing pass: until the first reseed it reads as zero.
// One request is worked on at a time; a finished result waits in an output register, and the
// next request is taken while it does.
module mersenne_twister_rng (
   input logic      clock,
   input logic      reset,
   mtr_req_if.sink  req_port,
   mtr_rsp_if.source rsp_port
);

   // Command and status structs are the only link between sequencer and datapath.
   mtr_pkg::cmd_type    cmd;
   mtr_pkg::status_type status;

   mtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the store, the result slot and the remainder unit.
   mtr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_port.operation),
      .req_argument  (req_port.argument),
      .rsp_ready     (rsp_port.ready),
      .rsp_valid     (rsp_port.valid),
      .rsp_value     (rsp_port.value)
   );

endmodule
